// File: rtl/core/scle_pkg.sv
// Shared constants, types and key tables of the scancode line editor.
`default_nettype none

package scle_pkg;

  // Line store geometry.
  localparam int STORE_DEPTH   = 64;
  localparam int LINE_CAPACITY = 64;
  localparam int POS_W         = $clog2(STORE_DEPTH);
  localparam int LINE_LIMIT_I  = (LINE_CAPACITY - 1 > STORE_DEPTH - 1) ?
                                 STORE_DEPTH - 1 : LINE_CAPACITY - 1;
  localparam logic [POS_W-1:0] LINE_LIMIT = POS_W'(LINE_LIMIT_I);

  // Field widths.
  localparam int SC_W   = 8;
  localparam int CHAR_W = 7;
  localparam int KIND_W = 2;

  // Scancodes with a fixed meaning.
  localparam logic [SC_W-1:0] SC_LSHIFT   = 8'h2A;
  localparam logic [SC_W-1:0] SC_RSHIFT   = 8'h36;
  localparam logic [SC_W-1:0] SC_BREAK    = 8'h80;
  localparam logic [SC_W-1:0] SC_ENTER    = 8'h1C;
  localparam logic [SC_W-1:0] SC_BKSP     = 8'h0E;
  localparam int              TABLE_LEN   = 58;
  localparam int              TIDX_W      = $clog2(TABLE_LEN);

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ECHO      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERASE     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LINE_CHAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LINE_END  = 2'd3;

  // Decoded operation of one scancode.
  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_SHIFT_SET = 3'd1,
    OP_SHIFT_CLR = 3'd2,
    OP_ENTER     = 3'd3,
    OP_BKSP      = 3'd4,
    OP_CHAR      = 3'd5
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  // Line store access from the sequencer.
  typedef struct packed {
    logic              we;
    logic [POS_W-1:0]  waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [POS_W-1:0]  raddr;
  } mem_req_t;

  // US layout, set 1, without shift.
  localparam logic [CHAR_W-1:0] PLAIN_KEYS [TABLE_LEN] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  // US layout, set 1, with shift held.
  localparam logic [CHAR_W-1:0] SHIFTED_KEYS [TABLE_LEN] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

endpackage

`default_nettype wire

// File: rtl/core/scle_in_if.sv
// Scancode request channel.
`default_nettype none

interface scle_in_if;
  logic                       valid;
  logic                       ready;
  logic [scle_pkg::SC_W-1:0]  scan_code;

  modport source (output valid, output scan_code, input ready);
  modport sink   (input valid, input scan_code, output ready);
endinterface

`default_nettype wire

// File: rtl/core/scle_out_if.sv
// Result request channel.
`default_nettype none

interface scle_out_if;
  logic                        valid;
  logic                        ready;
  logic [scle_pkg::KIND_W-1:0] kind;
  logic [scle_pkg::CHAR_W-1:0] character;
  logic                        last;

  modport source (output valid, output kind, output character, output last, input ready);
  modport sink   (input valid, input kind, input character, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/scle_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module scle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/scle_xlat.sv
// Scancode decoder: classifies a scancode and looks up its character.
`default_nettype none

module scle_xlat (
  input  wire logic [scle_pkg::SC_W-1:0] scan_code,
  input  wire logic                      shift_held,
  output scle_pkg::cmd_t                 cmd
);

  logic [scle_pkg::TIDX_W-1:0] tidx;
  logic                        in_table;
  logic [scle_pkg::CHAR_W-1:0] key_ch;

  // Table lookup, valid only for make codes below the table length.
  assign in_table = (scan_code < scle_pkg::SC_W'(scle_pkg::TABLE_LEN));
  assign tidx     = scan_code[scle_pkg::TIDX_W-1:0];

  always_comb begin
    key_ch = '0;
    if (in_table) begin
      key_ch = shift_held ? scle_pkg::SHIFTED_KEYS[tidx] : scle_pkg::PLAIN_KEYS[tidx];
    end
  end

  // Classification; special keys take precedence over the table.
  always_comb begin
    cmd.op = scle_pkg::OP_NONE;
    cmd.ch = key_ch;
    if (scan_code == scle_pkg::SC_LSHIFT || scan_code == scle_pkg::SC_RSHIFT) begin
      cmd.op = scle_pkg::OP_SHIFT_SET;
    end else if (scan_code == (scle_pkg::SC_LSHIFT | scle_pkg::SC_BREAK) ||
                 scan_code == (scle_pkg::SC_RSHIFT | scle_pkg::SC_BREAK)) begin
      cmd.op = scle_pkg::OP_SHIFT_CLR;
    end else if (scan_code == scle_pkg::SC_ENTER) begin
      cmd.op = scle_pkg::OP_ENTER;
    end else if (scan_code == scle_pkg::SC_BKSP) begin
      cmd.op = scle_pkg::OP_BKSP;
    end else if (in_table && key_ch != '0) begin
      cmd.op = scle_pkg::OP_CHAR;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/scle_ctrl.sv
// Sequencer: shift flag, write position, line walk and result register.
`default_nettype none

module scle_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire scle_pkg::cmd_t              cmd,
  output logic                             shift_held,
  output scle_pkg::mem_req_t               mem_req,
  input  wire logic [scle_pkg::CHAR_W-1:0] mem_rdata,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [scle_pkg::KIND_W-1:0] out_kind,
  output logic      [scle_pkg::CHAR_W-1:0] out_character,
  output logic                             out_last
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EMIT   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                      state_r, state_nxt;
  logic                        shift_r, shift_nxt;
  logic [scle_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [scle_pkg::POS_W-1:0]  idx_r, idx_nxt;
  logic [scle_pkg::POS_W-1:0]  idx_inc;
  logic                        out_valid_r, out_valid_nxt;
  logic [scle_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [scle_pkg::CHAR_W-1:0] char_r, char_nxt;
  logic                        last_r, last_nxt;
  logic                        load;
  logic                        slot_free;
  logic                        accept;

  // The result register is free when empty or being drained this cycle.
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign idx_inc   = idx_r + 1'b1;

  // Next-state and result selection.
  always_comb begin
    state_nxt = state_r;
    shift_nxt = shift_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    load      = 1'b0;
    kind_nxt  = kind_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    mem_req   = '0;
    mem_req.waddr = pos_r;
    mem_req.wdata = cmd.ch;
    mem_req.raddr = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd.op)
            scle_pkg::OP_SHIFT_SET: shift_nxt = 1'b1;
            scle_pkg::OP_SHIFT_CLR: shift_nxt = 1'b0;
            scle_pkg::OP_ENTER: begin
              if (pos_r == '0) begin
                load     = 1'b1;
                kind_nxt = scle_pkg::KIND_LINE_END;
                char_nxt = '0;
                last_nxt = 1'b1;
              end else begin
                // Start the walk with a read of the first entry.
                mem_req.re    = 1'b1;
                mem_req.raddr = '0;
                idx_nxt       = '0;
                state_nxt     = ST_EMIT;
              end
            end
            scle_pkg::OP_BKSP: begin
              if (pos_r != '0) begin
                pos_nxt  = pos_r - 1'b1;
                load     = 1'b1;
                kind_nxt = scle_pkg::KIND_ERASE;
                char_nxt = '0;
                last_nxt = 1'b1;
              end
            end
            scle_pkg::OP_CHAR: begin
              if (pos_r < scle_pkg::LINE_LIMIT) begin
                mem_req.we = 1'b1;
                pos_nxt    = pos_r + 1'b1;
                load       = 1'b1;
                kind_nxt   = scle_pkg::KIND_ECHO;
                char_nxt   = cmd.ch;
                last_nxt   = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        // Read data for entry idx_r is present; hand it on and fetch the next.
        if (slot_free) begin
          load     = 1'b1;
          kind_nxt = scle_pkg::KIND_LINE_CHAR;
          char_nxt = mem_rdata;
          last_nxt = 1'b0;
          if (idx_inc == pos_r) begin
            state_nxt = ST_FINISH;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = idx_inc;
            idx_nxt       = idx_inc;
          end
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          load      = 1'b1;
          kind_nxt  = scle_pkg::KIND_LINE_END;
          char_nxt  = '0;
          last_nxt  = 1'b1;
          pos_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      shift_r     <= 1'b0;
      pos_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      shift_r     <= shift_nxt;
      pos_r       <= pos_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_nxt;
      char_r <= char_nxt;
      last_r <= last_nxt;
    end
  end

  assign shift_held    = shift_r;
  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_character = char_r;
  assign out_last      = last_r;

endmodule

`default_nettype wire

// File: rtl/core/scancode_line_editor_core.sv
// Top level of the scancode line editor.
// A key with a single result has it in the output register in the cycle after acceptance.
// Throughput: one scancode per cycle while the result side keeps up.
// Enter with n stored characters gives n+1 results, one per cycle from the line store's
// read port unless stalled, and input stays stalled until the line-end result is loaded.
// Reset clears the shift flag, write position and sequencer; the line store is not cleared.
`default_nettype none

module scancode_line_editor_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  scle_in_if.sink    in_chan,
  scle_out_if.source out_chan
);

  scle_pkg::cmd_t              cmd;
  scle_pkg::mem_req_t          mem_req;
  logic [scle_pkg::CHAR_W-1:0] mem_rdata;
  logic                        shift_held;

  // Scancode decode.
  scle_xlat u_xlat (
    .scan_code  (in_chan.scan_code),
    .shift_held (shift_held),
    .cmd        (cmd)
  );

  // Line store.
  scle_ram #(
    .WIDTH (scle_pkg::CHAR_W),
    .DEPTH (scle_pkg::STORE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // Sequencer and result register.
  scle_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_chan.valid),
    .in_ready      (in_chan.ready),
    .cmd           (cmd),
    .shift_held    (shift_held),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_kind      (out_chan.kind),
    .out_character (out_chan.character),
    .out_last      (out_chan.last)
  );

endmodule

`default_nettype wire

// File: rtl/core/scle_checker.sv
// Port-level checks of the scancode line editor, bound to the top level.
`default_nettype none

module scle_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [scle_pkg::KIND_W-1:0] out_kind,
  input wire logic [scle_pkg::CHAR_W-1:0] out_character,
  input wire logic                        out_last
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
                                $stable(out_character) && $stable(out_last))
    else $error("stalled result changed");

  // A line end closes its request and carries no character.
  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == scle_pkg::KIND_LINE_END |-> out_last && out_character == '0)
    else $error("line end malformed");

  // Line characters are never last, and no new request is taken during the walk.
  a_line_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == scle_pkg::KIND_LINE_CHAR |-> !out_last && !in_ready)
    else $error("line character malformed or input open during walk");

  // An echo carries a real character and ends its request.
  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == scle_pkg::KIND_ECHO |-> out_last && out_character != '0)
    else $error("echo malformed");

endmodule

bind scancode_line_editor_core scle_checker u_scle_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_kind      (out_chan.kind),
  .out_character (out_chan.character),
  .out_last      (out_chan.last)
);

`default_nettype wire

// File: tb/sv/scancode_line_editor_core_tb.sv
// Self-checking testbench for the scancode line editor core.
`timescale 1ns / 1ps

module scancode_line_editor_core_tb;
  import scle_pkg::*;

  localparam int CLK_HALF_NS    = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_ITEMS   = 345;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 16;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int LINE_FILL_MAX  = (LINE_CAPACITY - 1 > STORE_DEPTH - 1) ?
                                  STORE_DEPTH - 1 : LINE_CAPACITY - 1;

  // US layout key maps, set 1, plain and with shift held.
  localparam logic [CHAR_W-1:0] US_PLAIN [TABLE_LEN] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };
  localparam logic [CHAR_W-1:0] US_SHIFTED [TABLE_LEN] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] character;
    logic              last;
  } line_result_t;

  // One directed scancode; pinned rows carry a hand-written expectation.
  typedef struct packed {
    logic [SC_W-1:0]   code;
    logic              pinned;
    logic              has_result;
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] character;
    logic              last;
  } key_row_t;

  localparam int N_DIRECTED = 25;
  localparam key_row_t DIRECTED_KEYS [N_DIRECTED] = '{
    '{SC_BKSP,              1'b1, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{SC_ENTER,             1'b1, 1'b1, KIND_LINE_END,  7'h00, 1'b1},
    '{8'h00,                1'b1, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{8'hFF,                1'b1, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{8'h80,                1'b1, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{8'h3A,                1'b1, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{8'h7F,                1'b1, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{8'h39,                1'b1, 1'b1, KIND_ECHO,      7'h20, 1'b1},
    '{8'h01,                1'b1, 1'b1, KIND_ECHO,      7'h1B, 1'b1},
    '{8'h9E,                1'b1, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{SC_LSHIFT,            1'b1, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{8'h10,                1'b1, 1'b1, KIND_ECHO,      7'h51, 1'b1},
    '{SC_LSHIFT | SC_BREAK, 1'b1, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{8'h10,                1'b0, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{SC_RSHIFT,            1'b1, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{8'h02,                1'b0, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{8'h35,                1'b0, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{SC_RSHIFT | SC_BREAK, 1'b1, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{8'h1D,                1'b1, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{8'h9C,                1'b1, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{8'h8E,                1'b1, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{SC_BKSP,              1'b1, 1'b1, KIND_ERASE,     7'h00, 1'b1},
    '{8'h0F,                1'b0, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{SC_ENTER,             1'b0, 1'b0, KIND_ECHO,      7'h00, 1'b0},
    '{SC_BKSP,              1'b1, 1'b0, KIND_ECHO,      7'h00, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;
  bit   hold_req;
  int   failures;
  int   burst_left;

  // Predictor state and the results it still expects.
  bit                shift_flag;
  logic [CHAR_W-1:0] typed_line [STORE_DEPTH];
  int                line_len;
  line_result_t      pending_results [$];

  scle_in_if  in_chan ();
  scle_out_if out_chan ();

  scancode_line_editor_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 1'b0;
  end

  // Work out the results of one scancode and queue them; returns how many.
  function automatic int predict_line_edit(input logic [SC_W-1:0] sc);
    logic [CHAR_W-1:0] ch;
    int                n;
    n = 0;
    if (sc == SC_LSHIFT || sc == SC_RSHIFT) begin
      shift_flag = 1'b1;
    end else if (sc == (SC_LSHIFT | SC_BREAK) || sc == (SC_RSHIFT | SC_BREAK)) begin
      shift_flag = 1'b0;
    end else if (sc == SC_ENTER) begin
      for (int i = 0; i < line_len; i++) begin
        pending_results.push_back(line_result_t'{KIND_LINE_CHAR, typed_line[i], 1'b0});
        n++;
      end
      pending_results.push_back(line_result_t'{KIND_LINE_END, 7'h00, 1'b1});
      n++;
      line_len = 0;
    end else if (sc == SC_BKSP) begin
      if (line_len > 0) begin
        line_len--;
        pending_results.push_back(line_result_t'{KIND_ERASE, 7'h00, 1'b1});
        n++;
      end
    end else if (!sc[7] && sc < TABLE_LEN) begin
      ch = shift_flag ? US_SHIFTED[sc] : US_PLAIN[sc];
      // A full line drops the character without an echo.
      if (ch != 7'h00 && line_len < LINE_FILL_MAX) begin
        typed_line[line_len] = ch;
        line_len++;
        pending_results.push_back(line_result_t'{KIND_ECHO, ch, 1'b1});
        n++;
      end
    end
    return n;
  endfunction

  // A make code that always gives a character, never enter or backspace.
  function automatic logic [SC_W-1:0] pick_char_key();
    int k;
    do begin
      k = $urandom_range(1, TABLE_LEN - 1);
    end while (US_PLAIN[k] == 7'h00 || k == SC_ENTER || k == SC_BKSP);
    return SC_W'(k);
  endfunction

  // Offer one scancode request and wait until it is taken.
  task automatic send_scancode(input logic [SC_W-1:0] sc, input key_row_t row);
    int n;
    @(negedge clk);
    in_chan.valid     <= 1'b1;
    in_chan.scan_code <= sc;
    do @(posedge clk); while (!in_chan.ready);
    n = predict_line_edit(sc);
    if (row.pinned) begin
      repeat (n) void'(pending_results.pop_back());
      if (row.has_result)
        pending_results.push_back(line_result_t'{row.kind, row.character, row.last});
    end
  endtask

  // Sender pacing: bursts of back-to-back requests separated by idle gaps.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) :
                                                 $urandom_range(0, 10);
    end
  endtask

  // Result side: changing stall patterns, plus one long hold-off on request.
  initial begin : result_sink
    int cyc;
    int mode;
    out_chan.ready = 1'b0;
    cyc  = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (cyc % 50 == 0)
          mode = $urandom_range(0, 3);
        case (mode)
          0: out_chan.ready <= 1'b1;
          1: out_chan.ready <= 1'($urandom_range(0, 1));
          2: out_chan.ready <= (cyc % 4 == 0);
          default: out_chan.ready <= ($urandom_range(0, 9) != 0);
        endcase
        cyc++;
      end
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    line_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d character 0x%02h last %0b",
               out_chan.kind, out_chan.character, out_chan.last);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_chan.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_chan.kind);
          failures++;
        end
        if (out_chan.character !== want.character) begin
          $error("character: expected 0x%02h, actual 0x%02h",
                 want.character, out_chan.character);
          failures++;
        end
        if (out_chan.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_chan.last);
          failures++;
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * CLK_HALF_NS);
    $display("** scancode_line_editor_core: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int       random_items;
    int       len;
    int       pick;
    bit       first_line;
    key_row_t free_row;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.scan_code = '0;
    hold_req          = 1'b0;
    failures          = 0;
    burst_left        = 0;
    shift_flag        = 1'b0;
    line_len          = 0;
    free_row          = '0;
    random_items      = 0;
    first_line        = 1'b1;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: edge codes, each operation and each special case.
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_scancode(DIRECTED_KEYS[i].code, DIRECTED_KEYS[i]);
      pace_sender();
    end

    // Random lines. The first one is long enough to fill the line store
    // while the result side holds off, so that the input backs up.
    hold_req = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      len = first_line ? 70 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 12);
      for (int k = 0; k < len; k++) begin
        pick = first_line ? 99 : $urandom_range(0, 99);
        if (pick < 8) begin
          send_scancode($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT, free_row);
          random_items++;
        end else if (pick < 16) begin
          send_scancode(($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT) | SC_BREAK, free_row);
          random_items++;
        end else if (pick < 24) begin
          send_scancode(SC_BKSP, free_row);
          random_items++;
        end else if (pick < 30) begin
          // Noise over the whole byte range.
          send_scancode(SC_W'($urandom_range(0, 255)), free_row);
          random_items++;
        end else if (pick < 34) begin
          send_scancode(pick_char_key() | SC_BREAK, free_row);
          random_items++;
        end else begin
          send_scancode(pick_char_key(), free_row);
          random_items++;
        end
        pace_sender();
      end
      send_scancode(SC_ENTER, free_row);
      random_items++;
      pace_sender();
      first_line = 1'b0;
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;

    // Drain, then watch a little longer for stray results.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("** scancode_line_editor_core: PASSED **");
    end else begin
      $display("** scancode_line_editor_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/scle_pkg.sv
rtl/core/scle_in_if.sv
rtl/core/scle_out_if.sv
rtl/core/scle_ram.sv
rtl/core/scle_xlat.sv
rtl/core/scle_ctrl.sv
rtl/core/scancode_line_editor_core.sv
rtl/core/scle_checker.sv
tb/sv/scancode_line_editor_core_tb.sv
